// File: sv/rfva_pkg.sv
// ============================================================================
// rfva_pkg
// Shared types and codes for the ring allocator of variable-size blocks.
// ============================================================================
package rfva_pkg;

    localparam int ACTION_W  = 2;
    localparam int REQ_W     = 12;
    localparam int OFFSET_W  = 13;
    localparam int STATUS_W  = 3;
    localparam int LEN_W     = 13;
    localparam int MIN_BYTES = 8;

    // register index of buffer_size
    localparam logic REG_BUFFER_SIZE = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_UNDO  = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_BADPTR = 3'd2,
        STAT_ORDER  = 3'd3,
        STAT_SIZE   = 3'd4,
        STAT_UNDO   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_en;   // one length-store entry cleared this cycle
        logic accept;     // input word taken, header read issued
        logic exec;       // update state and load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done; // last entry of the clearing pass
    } dp_stat_t;

    typedef struct packed {
        logic                we;
        logic [OFFSET_W-1:0] value;
    } cfg_wr_t;

endpackage

// File: sv/rfva_ctrl.sv
// ============================================================================
// rfva_ctrl
// Sequencer: clearing pass, accept, execute, result handshake.
// ============================================================================
module rfva_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  rfva_pkg::dp_stat_t stat,
    output rfva_pkg::dp_cmd_t  cmd
);

    rfva_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rfva_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rfva_pkg::ST_CLEAR: begin
                if (stat.clear_done) state_next = rfva_pkg::ST_IDLE;
            end
            rfva_pkg::ST_IDLE: begin
                if (s_valid) state_next = rfva_pkg::ST_EXEC;
            end
            rfva_pkg::ST_EXEC: begin
                if (out_free) state_next = rfva_pkg::ST_IDLE;
            end
            default: state_next = rfva_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        cmd.clear_en = (state_reg == rfva_pkg::ST_CLEAR);
        cmd.accept   = (state_reg == rfva_pkg::ST_IDLE) && s_valid;
        cmd.exec     = (state_reg == rfva_pkg::ST_EXEC) && out_free;
        s_ready      = (state_reg == rfva_pkg::ST_IDLE);
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sv/rfva_datapath.sv
// ============================================================================
// rfva_datapath
// Offsets, full flag, length store and result register.
// ============================================================================
module rfva_datapath #(
    parameter int BUF_BYTES    = 4096,
    parameter int HEADER_BYTES = 4,
    parameter int OFS_W        = 13
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rfva_pkg::dp_cmd_t                   cmd,
    output rfva_pkg::dp_stat_t                  stat,
    input  rfva_pkg::cfg_wr_t                   cfg,
    output logic [OFS_W-1:0]                    buffer_size,
    input  logic [rfva_pkg::ACTION_W-1:0]       s_action,
    input  logic [rfva_pkg::REQ_W-1:0]          s_req_size,
    input  logic [rfva_pkg::OFFSET_W-1:0]       s_block_offset,
    output logic [rfva_pkg::STATUS_W-1:0]       m_status,
    output logic [rfva_pkg::OFFSET_W-1:0]       m_payload_offset,
    output logic [rfva_pkg::OFFSET_W-1:0]       m_largest_span
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = ((OFS_W > rfva_pkg::OFFSET_W) ? OFS_W : rfva_pkg::OFFSET_W) + 1;
    localparam int RESET_SIZE = (BUF_BYTES < 4096) ? BUF_BYTES : 4096;

    localparam logic [CW-1:0]    HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0]    MAX_C   = CW'(BUF_BYTES);
    localparam logic [CW-1:0]    MIN_C   = CW'(rfva_pkg::MIN_BYTES);
    localparam logic [AW-1:0]    LAST_AD = AW'(BUF_BYTES - 1);

    // allocator state
    logic [OFS_W-1:0] bufsz_reg, begin_reg, end_reg;
    logic             full_reg;
    logic [OFS_W-1:0] begin_next, end_next;
    logic             full_next;

    // latched request
    logic [rfva_pkg::ACTION_W-1:0] act_reg;
    logic [rfva_pkg::REQ_W-1:0]    req_reg;
    logic [rfva_pkg::OFFSET_W-1:0] blk_reg;

    // length store
    logic [rfva_pkg::LEN_W-1:0] len_mem [BUF_BYTES];
    logic [rfva_pkg::LEN_W-1:0] rd_data_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic [rfva_pkg::LEN_W-1:0] wr_data;
    logic                       mem_we;
    logic [CW-1:0]              rd_hdr_c;

    // result register
    logic [rfva_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [rfva_pkg::OFFSET_W-1:0] payload_reg, payload_next;
    logic [rfva_pkg::OFFSET_W-1:0] span_reg, span_next;

    // execute-stage arithmetic
    logic [CW-1:0] bs_c, beg_c, end_c, need_c, hdr_c, len_c, cfg_c, clamp_c;
    logic [CW-1:0] start_c, alloc_hdr_c, alloc_end_c, lim_u_c, lim_f_c;
    logic [CW-1:0] sum_c, new_beg_c, s1_c, s2_c, span_c;
    logic          tail_ok, wrap_ok, alloc_ok, ptr_bad;

    // config clamp to MIN_BYTES .. BUF_BYTES
    assign cfg_c = CW'(cfg.value);
    always_comb begin
        priority if (cfg_c < MIN_C) begin
            clamp_c = MIN_C;
        end else if (cfg_c > MAX_C) begin
            clamp_c = MAX_C;
        end else begin
            clamp_c = cfg_c;
        end
    end

    assign bs_c   = CW'(bufsz_reg);
    assign beg_c  = CW'(begin_reg);
    assign end_c  = CW'(end_reg);
    assign need_c = CW'(req_reg) + HDR_C;
    assign hdr_c  = CW'(blk_reg) - HDR_C;
    assign len_c  = CW'(rd_data_reg);
    assign sum_c  = hdr_c + len_c;

    // allocate: tail first, then wrap to the front
    assign tail_ok     = (end_c >= beg_c) && ((bs_c - end_c) >= need_c);
    assign start_c     = (end_c <= beg_c) ? end_c : '0;
    assign wrap_ok     = (beg_c - start_c) >= need_c;
    assign alloc_ok    = !full_reg && (tail_ok || wrap_ok);
    assign alloc_hdr_c = tail_ok ? end_c : start_c;
    assign alloc_end_c = ((alloc_hdr_c + need_c) == bs_c) ? '0 : (alloc_hdr_c + need_c);

    assign ptr_bad = (CW'(blk_reg) < HDR_C) || (hdr_c >= bs_c);
    assign lim_u_c = (end_c == '0) ? bs_c : end_c;
    assign lim_f_c = (end_c > beg_c) ? end_c : bs_c;
    assign new_beg_c = (sum_c == bs_c) ? '0 : sum_c;

    // largest span
    always_comb begin
        if (end_c >= beg_c) begin
            s1_c = bs_c - end_c;
            s2_c = beg_c;
        end else begin
            s1_c = beg_c - end_c;
            s2_c = s1_c;
        end
        span_c = full_reg ? '0 : ((s1_c < s2_c) ? s2_c : s1_c);
    end

    // next state and result
    always_comb begin
        begin_next   = begin_reg;
        end_next     = end_reg;
        full_next    = full_reg;
        status_next  = rfva_pkg::STAT_OK;
        payload_next = '0;
        span_next    = '0;
        unique case (rfva_pkg::action_t'(act_reg))
            rfva_pkg::ACT_ALLOC: begin
                if (alloc_ok) begin
                    end_next     = OFS_W'(alloc_end_c);
                    full_next    = (alloc_end_c == beg_c);
                    payload_next = rfva_pkg::OFFSET_W'(alloc_hdr_c + HDR_C);
                end else begin
                    status_next = rfva_pkg::STAT_FULL;
                end
            end
            rfva_pkg::ACT_UNDO: begin
                priority if (ptr_bad) begin
                    status_next = rfva_pkg::STAT_BADPTR;
                end else if (sum_c != lim_u_c) begin
                    status_next = rfva_pkg::STAT_UNDO;
                end else begin
                    end_next  = OFS_W'(hdr_c);
                    full_next = 1'b0;
                end
            end
            rfva_pkg::ACT_FREE: begin
                priority if (ptr_bad) begin
                    status_next = rfva_pkg::STAT_BADPTR;
                end else if (hdr_c != beg_c && hdr_c != '0) begin
                    status_next = rfva_pkg::STAT_ORDER;
                end else if (sum_c > lim_f_c) begin
                    status_next = rfva_pkg::STAT_SIZE;
                end else begin
                    full_next = 1'b0;
                    if (new_beg_c == end_c) begin
                        begin_next = '0;
                        end_next   = '0;
                    end else begin
                        begin_next = OFS_W'(new_beg_c);
                    end
                end
            end
            rfva_pkg::ACT_QUERY: begin
                span_next = rfva_pkg::OFFSET_W'(span_c);
            end
            default: status_next = rfva_pkg::STAT_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bufsz_reg    <= OFS_W'(RESET_SIZE);
            begin_reg    <= '0;
            end_reg      <= '0;
            full_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end else begin
            if (cfg.we) begin
                bufsz_reg <= OFS_W'(clamp_c);
                begin_reg <= '0;
                end_reg   <= '0;
                full_reg  <= 1'b0;
            end else if (cmd.exec) begin
                begin_reg <= begin_next;
                end_reg   <= end_next;
                full_reg  <= full_next;
            end
            if (cmd.clear_en) clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // request and result registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg <= s_action;
            req_reg <= s_req_size;
            blk_reg <= s_block_offset;
        end
        if (cmd.exec) begin
            status_reg  <= status_next;
            payload_reg <= payload_next;
            span_reg    <= span_next;
        end
    end

    // length store: header read on accept, write on clear or allocate
    assign rd_hdr_c = CW'(s_block_offset) - HDR_C;
    assign rd_addr  = rd_hdr_c[AW-1:0];
    assign mem_we   = cmd.clear_en || (cmd.exec && alloc_ok &&
                      (rfva_pkg::action_t'(act_reg) == rfva_pkg::ACT_ALLOC));
    assign wr_addr  = cmd.clear_en ? clr_addr_reg : alloc_hdr_c[AW-1:0];
    assign wr_data  = cmd.clear_en ? '0 : rfva_pkg::LEN_W'(need_c);

    always_ff @(posedge aclk) begin
        if (mem_we) len_mem[wr_addr] <= wr_data;
        if (cmd.accept) rd_data_reg <= len_mem[rd_addr];
    end

    assign stat.clear_done  = cmd.clear_en && (clr_addr_reg == LAST_AD);
    assign buffer_size      = bufsz_reg;
    assign m_status         = status_reg;
    assign m_payload_offset = payload_reg;
    assign m_largest_span   = span_reg;

endmodule

// File: sv/ring_fifo_variable_allocator_core.sv
// Flow: the header is read at the accept edge and the word executes in the
//   EXEC state that follows; no word is taken while one executes, so a new
//   word waits until the last one has executed; execute waits while the
//   result register still holds an untaken word.
// Reset: synchronous, active low. Offsets and full flag clear at once; then a
//   clearing pass zeroes the length store, no input taken.
// ============================================================================
// ring_fifo_variable_allocator_core
// Ring allocator of variable-size blocks with length headers, APB config.
// ============================================================================
module ring_fifo_variable_allocator_core #(
    parameter int BUF_BYTES    = 4096,
    parameter int HEADER_BYTES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rfva_pkg::ACTION_W-1:0]       s_action,
    input  logic [rfva_pkg::REQ_W-1:0]          s_req_size,
    input  logic [rfva_pkg::OFFSET_W-1:0]       s_block_offset,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rfva_pkg::STATUS_W-1:0]       m_status,
    output logic [rfva_pkg::OFFSET_W-1:0]       m_payload_offset,
    output logic [rfva_pkg::OFFSET_W-1:0]       m_largest_span
);

    // offset width: holds every offset and BUF_BYTES itself
    localparam int OFS_W = $clog2(BUF_BYTES + 1);

    rfva_pkg::dp_cmd_t  cmd;
    rfva_pkg::dp_stat_t stat;
    rfva_pkg::cfg_wr_t  cfg;
    logic [OFS_W-1:0]   buffer_size;
    logic               reg_sel;

    // APB: no wait states; word index is paddr[2]
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == rfva_pkg::REG_BUFFER_SIZE);
    assign cfg.we    = psel && penable && pwrite && pready && reg_sel;
    assign cfg.value = pwdata[rfva_pkg::OFFSET_W-1:0];

    always_comb begin
        if (reg_sel) begin
            prdata = 32'(buffer_size);
        end else begin
            prdata = '0;
        end
    end

    // sequencer
    rfva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // offsets, length store, result register
    rfva_datapath #(
        .BUF_BYTES    (BUF_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .OFS_W        (OFS_W)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg              (cfg),
        .buffer_size      (buffer_size),
        .s_action         (s_action),
        .s_req_size       (s_req_size),
        .s_block_offset   (s_block_offset),
        .m_status         (m_status),
        .m_payload_offset (m_payload_offset),
        .m_largest_span   (m_largest_span)
    );

`ifndef SYNTHESIS
    // one word in flight: no second accept right after one
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous word executing");

    // execute loads the result register only when it is free
    a_exec_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // every execute shows a result word next cycle
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("result word missing after execute");
`endif

endmodule

// File: bench/ring_fifo_variable_allocator_core_test.sv
// ============================================================================
// ring_fifo_variable_allocator_core_test
// Self-checking bench for the ring allocator: a scoreboard class predicts each
// reply from its own copy of the offsets, full flag and length headers, and
// plain tasks drive requests, APB writes and a stalling reply receiver.
// ============================================================================
module ring_fifo_variable_allocator_core_test;

    localparam int BUF_BYTES  = 4096;
    localparam int HDR_BYTES  = 4;
    localparam int SPARE_REG  = 1;       // unmapped register index, writes dropped
    localparam int IDLE_LIMIT = 20000;   // covers the length-store clearing pass
    localparam int MAX_PRINTS = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: owns the predicted allocator state and the reply queue
    // ------------------------------------------------------------------------
    class ring_alloc_scoreboard;

        typedef struct {
            rfva_pkg::status_t             status;
            logic [rfva_pkg::OFFSET_W-1:0] payload;
            logic [rfva_pkg::OFFSET_W-1:0] span;
        } reply_t;

        int          size;
        int          head;               // header offset of oldest block
        int          tail;               // just past newest block
        bit          full;
        bit [rfva_pkg::LEN_W-1:0] hdr_len [BUF_BYTES];
        reply_t      awaited_replies[$];
        int          live_blocks[$];     // payload offsets, only to steer stimulus
        int          errors;
        int          checked;
        int          status_seen[6];

        function new();
            size = BUF_BYTES;
            head = 0;
            tail = 0;
            full = 1'b0;
            errors = 0;
            checked = 0;
            foreach (hdr_len[i]) hdr_len[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        task flag_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("tb: mismatch at reply %0d: %s", checked, what);
        endtask

        function int pending();
            return awaited_replies.size();
        endfunction

        function int free_span();
            int s1;
            int s2;
            if (full)
                return 0;
            if (tail >= head) begin
                s1 = size - tail;
                s2 = head;
            end else begin
                s1 = head - tail;
                s2 = s1;
            end
            return (s1 < s2) ? s2 : s1;
        endfunction

        function int oldest_block();
            return head + HDR_BYTES;
        endfunction

        function int newest_block();
            return (live_blocks.size() > 0) ? live_blocks[$] : head + HDR_BYTES;
        endfunction

        // writing buffer_size empties the ring; the length headers survive
        function void write_reg(int idx, logic [31:0] data);
            int v;
            if (idx != int'(rfva_pkg::REG_BUFFER_SIZE))
                return;
            v = int'(data[rfva_pkg::OFFSET_W-1:0]);
            if (v < rfva_pkg::MIN_BYTES) v = rfva_pkg::MIN_BYTES;
            if (v > BUF_BYTES) v = BUF_BYTES;
            size = v;
            head = 0;
            tail = 0;
            full = 1'b0;
            live_blocks.delete();
        endfunction

        function rfva_pkg::status_t try_alloc(int req, output int pay);
            int need;
            int start;
            need = req + HDR_BYTES;
            pay = 0;
            if (full)
                return rfva_pkg::STAT_FULL;
            // tail room first
            if (tail >= head && size - tail >= need) begin
                start = tail;
                tail += need;
                if (tail == size) tail = 0;
                if (tail == head) full = 1'b1;
            end else begin
                // wrap to the space below head
                start = (tail <= head) ? tail : 0;
                if (head - start < need)
                    return rfva_pkg::STAT_FULL;
                tail = start + need;
                if (tail == head) full = 1'b1;
            end
            hdr_len[start] = rfva_pkg::LEN_W'(need);
            pay = start + HDR_BYTES;
            live_blocks.push_back(pay);
            return rfva_pkg::STAT_OK;
        endfunction

        function rfva_pkg::status_t try_undo(int blk);
            int hdr;
            int lim;
            if (blk < HDR_BYTES)
                return rfva_pkg::STAT_BADPTR;
            hdr = blk - HDR_BYTES;
            if (hdr >= size)
                return rfva_pkg::STAT_BADPTR;
            lim = (tail == 0) ? size : tail;
            if (hdr + int'(hdr_len[hdr]) != lim)
                return rfva_pkg::STAT_UNDO;
            tail = hdr;
            full = 1'b0;
            if (live_blocks.size() > 0) void'(live_blocks.pop_back());
            return rfva_pkg::STAT_OK;
        endfunction

        function rfva_pkg::status_t try_free(int blk);
            int hdr;
            int lim;
            if (blk < HDR_BYTES)
                return rfva_pkg::STAT_BADPTR;
            hdr = blk - HDR_BYTES;
            if (hdr >= size)
                return rfva_pkg::STAT_BADPTR;
            if (hdr != head && hdr != 0)
                return rfva_pkg::STAT_ORDER;
            lim = (tail > head) ? tail : size;
            if (hdr + int'(hdr_len[hdr]) > lim)
                return rfva_pkg::STAT_SIZE;
            head = hdr + int'(hdr_len[hdr]);
            if (head == size) head = 0;
            if (head == tail) begin
                head = 0;
                tail = 0;
            end
            full = 1'b0;
            if (live_blocks.size() > 0) void'(live_blocks.pop_front());
            return rfva_pkg::STAT_OK;
        endfunction

        function void note_request(rfva_pkg::action_t act,
                                   logic [rfva_pkg::REQ_W-1:0] req,
                                   logic [rfva_pkg::OFFSET_W-1:0] blk);
            reply_t r;
            int     pay;
            r.status  = rfva_pkg::STAT_OK;
            r.payload = '0;
            r.span    = '0;
            pay = 0;
            case (act)
                rfva_pkg::ACT_ALLOC: begin
                    r.status  = try_alloc(int'(req), pay);
                    r.payload = rfva_pkg::OFFSET_W'(pay);
                end
                rfva_pkg::ACT_UNDO:  r.status = try_undo(int'(blk));
                rfva_pkg::ACT_FREE:  r.status = try_free(int'(blk));
                default:             r.span = rfva_pkg::OFFSET_W'(free_span());
            endcase
            awaited_replies.push_back(r);
        endfunction

        task check_reply(logic [rfva_pkg::STATUS_W-1:0] st,
                         logic [rfva_pkg::OFFSET_W-1:0] pay,
                         logic [rfva_pkg::OFFSET_W-1:0] span);
            reply_t r;
            if (awaited_replies.size() == 0) begin
                flag_mismatch("reply word with no request outstanding");
                return;
            end
            r = awaited_replies.pop_front();
            checked++;
            status_seen[r.status]++;
            if (st !== r.status)
                flag_mismatch($sformatf("status %0d, predicted %0d", st, r.status));
            if (pay !== r.payload)
                flag_mismatch($sformatf("payload_offset %0d, predicted %0d",
                                        pay, r.payload));
            if (span !== r.span)
                flag_mismatch($sformatf("largest_span %0d, predicted %0d", span, r.span));
        endtask

    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [2:0]                    paddr          = '0;
    logic [31:0]                   pwdata         = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [rfva_pkg::ACTION_W-1:0] s_action       = '0;
    logic [rfva_pkg::REQ_W-1:0]    s_req_size     = '0;
    logic [rfva_pkg::OFFSET_W-1:0] s_block_offset = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [rfva_pkg::STATUS_W-1:0] m_status;
    logic [rfva_pkg::OFFSET_W-1:0] m_payload_offset;
    logic [rfva_pkg::OFFSET_W-1:0] m_largest_span;

    ring_alloc_scoreboard sb = new();

    int burst_left   = 0;    // words still to send back to back
    int settings_run = 1;    // buffer sizes exercised, reset value included
    int idle_cycles  = 0;

    ring_fifo_variable_allocator_core #(
        .BUF_BYTES    (BUF_BYTES),
        .HEADER_BYTES (HDR_BYTES)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_req_size       (s_req_size),
        .s_block_offset   (s_block_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_offset (m_payload_offset),
        .m_largest_span   (m_largest_span)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Request side: one word per call, bursts with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_request(rfva_pkg::action_t act,
                                logic [rfva_pkg::REQ_W-1:0] req,
                                logic [rfva_pkg::OFFSET_W-1:0] blk);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_req_size     <= req;
        s_block_offset <= blk;
        do @(posedge aclk); while (!s_ready);
        // predict right away so the next word can be steered by the new state
        sb.note_request(act, req, blk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            // now and then a long back-to-back run
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Config is only touched with nothing in flight; pause covers the
    // read/execute pipeline.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic apb_write(int idx, logic [31:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, data);
        if (idx == int'(rfva_pkg::REG_BUFFER_SIZE)) settings_run++;
    endtask

    // Mostly well-formed traffic: frees of the oldest block, undo of the newest,
    // allocations sized to the buffer, queries; the rest is bad pointers.
    task automatic random_request();
        rfva_pkg::action_t             act;
        logic [rfva_pkg::REQ_W-1:0]    req;
        logic [rfva_pkg::OFFSET_W-1:0] blk;
        int                            pick;
        int                            span;
        int                            cap;
        int                            off;
        pick = $urandom_range(0, 99);
        span = sb.free_span();
        // unused fields still carry random content
        req  = rfva_pkg::REQ_W'($urandom_range(0, 4092));
        blk  = rfva_pkg::OFFSET_W'($urandom_range(0, BUF_BYTES));
        if (pick < 45) begin
            act = rfva_pkg::ACT_ALLOC;
            case ($urandom_range(0, 9))
                0: req = '0;
                1: if (span >= HDR_BYTES) req = rfva_pkg::REQ_W'(span - HDR_BYTES);
                2: ;                                   // anything in range
                default: begin
                    cap = sb.size / 6;
                    if (cap > 4092) cap = 4092;
                    req = rfva_pkg::REQ_W'($urandom_range(0, cap));
                end
            endcase
        end else if (pick < 70) begin
            act = rfva_pkg::ACT_FREE;
            blk = rfva_pkg::OFFSET_W'(sb.oldest_block());
        end else if (pick < 82) begin
            act = rfva_pkg::ACT_UNDO;
            blk = rfva_pkg::OFFSET_W'(sb.newest_block());
        end else if (pick < 90) begin
            act = rfva_pkg::ACT_QUERY;
        end else begin
            act = ($urandom_range(0, 1) != 0) ? rfva_pkg::ACT_UNDO : rfva_pkg::ACT_FREE;
            case ($urandom_range(0, 3))
                0: blk = rfva_pkg::OFFSET_W'($urandom_range(0, HDR_BYTES - 1));
                1: begin
                    // around the end of the buffer in use
                    off = sb.size + $urandom_range(0, HDR_BYTES);
                    if (off > BUF_BYTES) off = BUF_BYTES;
                    blk = rfva_pkg::OFFSET_W'(off);
                end
                2: blk = rfva_pkg::OFFSET_W'(BUF_BYTES);
                default: ;
            endcase
        end
        send_request(act, req, blk);
    endtask

    // ------------------------------------------------------------------------
    // Reply side: stall pattern switches between always ready, coin flips
    // and a 1-in-N duty, each held for a random stretch
    // ------------------------------------------------------------------------
    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_div   = 2;
    int rx_count = 0;

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_reply(m_status, m_payload_offset, m_largest_span);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_div  = $urandom_range(2, 6);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        rx_count++;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= (rx_count % rx_div) == 0;
        endcase
    end

    // watchdog: no handshake on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset buffer size; first words wait out the clearing pass
        send_request(rfva_pkg::ACT_QUERY, 12'd0,    13'd0);    // empty ring, whole buffer
        send_request(rfva_pkg::ACT_UNDO,  12'd5,    13'd4);    // never-written header
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd4);    // zero-length stale header
        send_request(rfva_pkg::ACT_ALLOC, 12'd0,    13'd0);    // header only
        send_request(rfva_pkg::ACT_ALLOC, 12'd4092, 13'd0);    // no room anywhere
        send_request(rfva_pkg::ACT_ALLOC, 12'd4088, 13'd0);    // exact fit, goes full
        send_request(rfva_pkg::ACT_QUERY, 12'd0,    13'd0);    // full: span zero
        send_request(rfva_pkg::ACT_ALLOC, 12'd0,    13'd0);    // refused while full
        send_request(rfva_pkg::ACT_UNDO,  12'd0,    13'd8);    // take back the last block
        send_request(rfva_pkg::ACT_UNDO,  12'd0,    13'd8);    // no longer ends at tail
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd12);   // not the oldest
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd3);    // below the header size
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd4);    // free empties the ring
        send_request(rfva_pkg::ACT_ALLOC, 12'd100,  13'd0);
        send_request(rfva_pkg::ACT_ALLOC, 12'd200,  13'd0);
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd4);
        send_request(rfva_pkg::ACT_ALLOC, 12'd3784, 13'd0);    // tail fit, end wraps to 0
        send_request(rfva_pkg::ACT_QUERY, 12'd0,    13'd0);
        send_request(rfva_pkg::ACT_ALLOC, 12'd96,   13'd0);    // wrap below head
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd4096); // top offset bit, out of order
        send_request(rfva_pkg::ACT_ALLOC, 12'd4092, 13'd0);

        // smallest buffer; written value below the floor saturates up
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'd3);
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd4);    // stale length past the region
        send_request(rfva_pkg::ACT_FREE,  12'd0,    13'd12);   // header beyond buffer size
        send_request(rfva_pkg::ACT_ALLOC, 12'd4,    13'd0);    // fills all 8 bytes
        send_request(rfva_pkg::ACT_UNDO,  12'd0,    13'd4);

        // random phases; each write empties the ring except the spare index
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'h0000_1FFF);   // saturates to max
        repeat (300) random_request();
        apb_write(SPARE_REG, 32'h0000_0010);                          // ignored, state kept
        repeat (150) random_request();
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'd8);
        repeat (120) random_request();
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'hFFFF_0040);   // upper bits dropped
        repeat (200) random_request();
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'd100);         // not a multiple of 4
        repeat (200) random_request();
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'd1000);
        repeat (200) random_request();
        apb_write(int'(rfva_pkg::REG_BUFFER_SIZE), 32'd4096);
        repeat (180) random_request();

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("tb: %0d replies checked over %0d buffer sizes",
                 sb.checked, settings_run);
        $display("tb: ok %0d, no room %0d, bad pointer %0d, order %0d, size %0d, undo %0d",
                 sb.status_seen[rfva_pkg::STAT_OK], sb.status_seen[rfva_pkg::STAT_FULL],
                 sb.status_seen[rfva_pkg::STAT_BADPTR], sb.status_seen[rfva_pkg::STAT_ORDER],
                 sb.status_seen[rfva_pkg::STAT_SIZE], sb.status_seen[rfva_pkg::STAT_UNDO]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
